FILE: src/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

   localparam int DATA_W = 64;
   localparam int CNT_W  = 5;
   localparam int ACT_W  = 3;

   // capacity after reset
   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

   localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd4;
   localparam logic [ACT_W-1:0] ACT_READ_FRONT = 3'd5;
   localparam logic [ACT_W-1:0] ACT_READ_BACK  = 3'd6;
   localparam logic [ACT_W-1:0] ACT_FIND       = 3'd7;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [DATA_W-1:0] name_key;
      logic [DATA_W-1:0] address_value;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [DATA_W-1:0] entry_name;
      logic [DATA_W-1:0] entry_address;
      logic [CNT_W-1:0]  entry_count;
   } rsp_type;

   // one ring slot as held in the entry memory
   typedef struct packed {
      logic [DATA_W-1:0] name;
      logic [DATA_W-1:0] address;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: src/bdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/bdq_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_seq #(
   parameter int DEPTH = 16,
   localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire bdq_pkg::req_type               req_data,
   output logic                                rsp_valid,
   output bdq_pkg::rsp_type                    rsp_data,
   input  wire logic [bdq_pkg::CNT_W-1:0]      cap_eff,
   output logic                                wr_en,
   output logic [IW-1:0]                       wr_addr,
   output bdq_pkg::entry_type                  wr_data,
   output logic                                rd_en,
   output logic [IW-1:0]                       rd_addr,
   input  wire bdq_pkg::entry_type             rd_data
);

   import bdq_pkg::*;

   localparam int SW = ((IW > CNT_W) ? IW : CNT_W) + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_FIND = 2'd3;

   logic [1:0]       state_ff, state_in;
   req_type          cmd_ff, cmd_in;
   logic [IW-1:0]    front_ff, front_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             full;
   logic             empty;
   logic [CNT_W-1:0] scan_nxt;
   logic [IW-1:0]    front_dec;
   logic [IW-1:0]    front_inc;

   // ring slot of front plus an offset of at most the depth
   function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
                                               input logic [CNT_W-1:0] offset);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(offset);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   assign full      = cnt_ff >= cap_eff;
   assign empty     = cnt_ff == '0;
   assign scan_nxt  = scan_ff + CNT_W'(1);
   assign front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - IW'(1);
   assign front_inc = ring_slot(front_ff, CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      front_in     = front_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = front_ff;
      wr_data      = {cmd_ff.name_key, cmd_ff.address_value};
      rd_en        = 1'b0;
      rd_addr      = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in   = '{status: STATUS_OK, entry_name: '0, entry_address: '0,
                         entry_count: cnt_ff};
            state_in = S_IDLE;
            unique case (cmd_ff.action)
               ACT_PUSH_FRONT: begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  cnt_in   = full ? cnt_ff : cnt_ff + CNT_W'(1);
               end
               ACT_PUSH_BACK: begin
                  // slot after the back; on a full queue the front is evicted
                  wr_en    = 1'b1;
                  wr_addr  = ring_slot(front_ff, cnt_ff);
                  front_in = full ? front_inc : front_ff;
                  cnt_in   = full ? cnt_ff : cnt_ff + CNT_W'(1);
               end
               ACT_POP_FRONT: begin
                  if (!empty) begin
                     front_in = front_inc;
                     cnt_in   = cnt_ff - CNT_W'(1);
                  end
               end
               ACT_POP_BACK: begin
                  if (!empty) begin
                     cnt_in = cnt_ff - CNT_W'(1);
                  end
               end
               ACT_CLEAR: begin
                  cnt_in = '0;
               end
               ACT_READ_FRONT, ACT_READ_BACK: begin
                  if (!empty) begin
                     rd_en    = 1'b1;
                     rd_addr  = (cmd_ff.action == ACT_READ_FRONT) ? front_ff
                              : ring_slot(front_ff, cnt_ff - CNT_W'(1));
                     state_in = S_READ;
                  end
               end
               ACT_FIND: begin
                  if (!empty) begin
                     rd_en    = 1'b1;
                     rd_addr  = front_ff;
                     scan_in  = '0;
                     state_in = S_FIND;
                  end
               end
               default: begin
               end
            endcase
            rsp_in.entry_count = cnt_in;
            if ((cmd_ff.action == ACT_POP_FRONT || cmd_ff.action == ACT_POP_BACK ||
                 cmd_ff.action == ACT_READ_FRONT || cmd_ff.action == ACT_READ_BACK ||
                 cmd_ff.action == ACT_FIND) && empty) begin
               rsp_in.status = STATUS_FAIL;
            end
            rsp_valid_in = (state_in == S_IDLE);
         end
         S_READ: begin
            rsp_in       = '{status: STATUS_OK, entry_name: rd_data.name,
                             entry_address: rd_data.address, entry_count: cnt_ff};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_FIND: begin
            // data of offset scan_ff is here; fetch the next slot meanwhile
            if (rd_data.name == cmd_ff.name_key) begin
               rsp_in       = '{status: STATUS_OK, entry_name: rd_data.name,
                                entry_address: rd_data.address, entry_count: cnt_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (scan_nxt == cnt_ff) begin
               rsp_in       = '{status: STATUS_FAIL, entry_name: '0,
                                entry_address: '0, entry_count: cnt_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ring_slot(front_ff, scan_nxt);
               scan_in = scan_nxt;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) != S_IDLE)
      else $error("result strobe without a command in progress");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= DEPTH)
      else $error("entry count exceeds ring depth");

   a_start_exec: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == S_IDLE) |=> state_ff == S_EXEC)
      else $error("accepted command did not enter execution");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FAIL) |->
         (rsp_ff.entry_name == '0 && rsp_ff.entry_address == '0))
      else $error("failed result carries entry data");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIND |-> scan_ff < cnt_ff)
      else $error("find scan ran past the held entries");

endmodule

`default_nettype wire

FILE: src/bounded_deque_with_eviction_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of 64-bit name/address pairs held in a ring of
// DEPTH slots in one registered-read memory. A command is taken when start is
// high and busy is low; its single result appears on rsp_data for exactly one
// cycle with rsp_valid high, and the receiver cannot stall it. Pushes, pops
// and clear are executed from the registered command and give a registered
// result; read front/back add a state for the registered memory read; a find
// reads one held entry per cycle through the single memory read port and
// stops at the first match or, when nothing matches, after the last held
// entry. The next command can be taken in the cycle the result is shown.
// Pushing onto a full queue evicts the opposite end. The capacity register
// (reset 16, 0 acts as 1, above DEPTH acts as DEPTH) is written through the
// always-ready csr channel, by the user only while idle; the block does not check.
module bounded_deque_with_eviction_top #(
   parameter int DEPTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire bdq_pkg::req_type          req_data,
   output logic                           rsp_valid,
   output bdq_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [bdq_pkg::CNT_W-1:0] csr_wdata
);

   import bdq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CNT_W-1:0] cap_ff;
   logic [CNT_W-1:0] cap_eff;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IW-1:0]    rd_addr;
   entry_type        rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_wdata;
      end
   end

   always_comb begin
      priority if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > DEPTH) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   bdq_seq #(
      .DEPTH(DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .cap_eff  (cap_eff),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   bdq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

`default_nettype wire
